/* rtl/core/bcl_pkg.sv */
package bcl_pkg;

  localparam int unsigned QDEPTH = 4;

  localparam logic [31:0] MIN_TICKS_RST = 32'd600;
  localparam logic [31:0] MAX_TICKS_RST = 32'd172800;
  localparam logic [31:0] HOLDOFF_RST   = 32'd86400;

  localparam logic [38:0] PCT_SCALE = 39'd100;
  localparam logic [38:0] PCT_LO    = 39'd80;
  localparam logic [38:0] PCT_HI    = 39'd120;

  localparam logic [9:0] LOW_SOC_LIMIT = 10'd100;
  localparam logic [9:0] FULL_SOC      = 10'd1000;

  localparam logic [1:0] REG_ENABLE  = 2'd0;
  localparam logic [1:0] REG_MIN     = 2'd1;
  localparam logic [1:0] REG_MAX     = 2'd2;
  localparam logic [1:0] REG_HOLDOFF = 2'd3;

  typedef enum logic [1:0] {
    OUT_NONE   = 2'd0,
    OUT_OPP    = 2'd1,
    OUT_TOTAL  = 2'd2,
    OUT_REJECT = 2'd3
  } outcome_e;

  typedef struct packed {
    logic        source;
    outcome_e    outcome;
    logic [31:0] meas;
    logic [31:0] ref_cap;
    logic [9:0]  soc;
  } res_t;

  typedef struct packed {
    logic dual;
    res_t r0;
    res_t r1;
  } entry_t;

  function automatic logic within_pct(input logic [31:0] ref_cap, input logic [31:0] cap);
    logic [38:0] v;
    logic [38:0] lo;
    logic [38:0] hi;
    v  = 39'(cap) * PCT_SCALE;
    lo = 39'(ref_cap) * PCT_LO;
    hi = 39'(ref_cap) * PCT_HI;
    return (v >= lo) && (v <= hi);
  endfunction

endpackage

/* rtl/core/bcl_front.sv */
module bcl_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  logic            need_comp_i,
  input  logic [31:0]     now_seconds_i,
  input  logic [31:0]     hist_charge_i,
  input  logic [31:0]     hist_discharge_i,
  input  logic [31:0]     present_total_i,
  input  logic            discharging_i,
  input  logic            at_full_i,
  input  logic            under_voltage_i,
  input  logic [9:0]      real_soc_i,
  input  logic [9:0]      display_soc_i,
  input  logic            check_enable_i,
  input  logic [31:0]     min_cycle_ticks_i,
  input  logic [31:0]     max_cycle_ticks_i,
  input  logic [31:0]     holdoff_seconds_i,
  input  logic            q_full_i,
  output logic            push_o,
  output bcl_pkg::entry_t entry_o
);

  logic        high_valid_q, high_valid_d, low_valid_q, low_valid_d;
  logic [31:0] high_charge_q, high_charge_d, high_dis_q, high_dis_d;
  logic [31:0] high_meas_q, high_meas_d, high_timer_q, high_timer_d;
  logic [31:0] low_charge_q, low_charge_d, low_dis_q, low_dis_d;
  logic [31:0] low_meas_q, low_meas_d, low_timer_q, low_timer_d;
  logic [31:0] hold_start_q, hold_start_d;
  logic        clear_done_q, clear_done_d, full_armed_q, full_armed_d;
  logic        empty_armed_q, empty_armed_d;

  logic        accept, in_hold, cnt_reset, active, rec_h, e0, e1, uv_low;
  logic [31:0] ht, lt, gain, loss, opp, tmr, calc, stored;
  logic        measurable;
  bcl_pkg::outcome_e outc;
  bcl_pkg::res_t     ev_res, none_res;

  assign ready_o = !q_full_i;
  assign accept  = valid_i && ready_o;
  assign in_hold = (now_seconds_i - hold_start_q) < holdoff_seconds_i;
  assign cnt_reset = (high_valid_q && (high_charge_q > hist_charge_i ||
                                       high_dis_q > hist_discharge_i)) ||
                     (low_valid_q && (low_charge_q > hist_charge_i ||
                                      low_dis_q > hist_discharge_i));
  assign active = accept && !need_comp_i && !in_hold && check_enable_i && !cnt_reset;
  assign rec_h  = at_full_i && full_armed_q;
  assign e0     = active && rec_h && low_valid_q;
  assign uv_low = under_voltage_i && (real_soc_i < bcl_pkg::LOW_SOC_LIMIT);
  assign e1     = active && discharging_i && uv_low && empty_armed_q &&
                  (rec_h || high_valid_q);
  assign ht     = high_timer_q + 32'd1;
  assign lt     = (e0 ? 32'd0 : low_timer_q) + 32'd1;

  // one real evaluation per tick; a high point taken this tick leaves no gain
  assign gain = e0 ? hist_charge_i - low_charge_q : hist_discharge_i - high_dis_q;
  assign loss = e0 ? hist_discharge_i - low_dis_q : hist_charge_i - high_charge_q;
  assign opp  = e0 ? low_meas_q : high_meas_q;
  assign tmr  = e0 ? ht : lt;
  assign calc = gain - loss;
  assign measurable = (e0 || !rec_h) && tmr >= min_cycle_ticks_i &&
                      tmr <= max_cycle_ticks_i && gain > loss;

  always_comb begin
    if (!measurable) begin
      outc = bcl_pkg::OUT_NONE;
    end else if (bcl_pkg::within_pct(opp, calc)) begin
      outc = bcl_pkg::OUT_OPP;
    end else if (bcl_pkg::within_pct(present_total_i, calc)) begin
      outc = bcl_pkg::OUT_TOTAL;
    end else begin
      outc = bcl_pkg::OUT_REJECT;
    end
  end

  assign stored = (outc == bcl_pkg::OUT_OPP || outc == bcl_pkg::OUT_TOTAL) ? calc : 32'd0;

  always_comb begin
    ev_res.source  = !e0;
    ev_res.outcome = outc;
    ev_res.meas    = measurable ? calc : 32'd0;
    ev_res.ref_cap = (outc == bcl_pkg::OUT_OPP) ? opp : present_total_i;
    ev_res.soc     = e0 ? bcl_pkg::FULL_SOC : display_soc_i;
    none_res.source  = 1'b1;
    none_res.outcome = bcl_pkg::OUT_NONE;
    none_res.meas    = 32'd0;
    none_res.ref_cap = 32'd0;
    none_res.soc     = 10'd0;
  end

  assign push_o        = e0 || e1;
  assign entry_o.dual  = e0 && e1;
  assign entry_o.r0    = ev_res;
  assign entry_o.r1    = none_res;

  always_comb begin
    high_valid_d  = high_valid_q;
    high_charge_d = high_charge_q;
    high_dis_d    = high_dis_q;
    high_meas_d   = high_meas_q;
    high_timer_d  = high_timer_q;
    low_valid_d   = low_valid_q;
    low_charge_d  = low_charge_q;
    low_dis_d     = low_dis_q;
    low_meas_d    = low_meas_q;
    low_timer_d   = low_timer_q;
    hold_start_d  = hold_start_q;
    clear_done_d  = clear_done_q;
    full_armed_d  = full_armed_q;
    empty_armed_d = empty_armed_q;
    if (accept) begin
      if (need_comp_i || in_hold || ((!check_enable_i || cnt_reset) && !clear_done_q)) begin
        high_valid_d  = 1'b0;
        high_charge_d = 32'd0;
        high_dis_d    = 32'd0;
        high_meas_d   = 32'd0;
        high_timer_d  = 32'd0;
        low_valid_d   = 1'b0;
        low_charge_d  = 32'd0;
        low_dis_d     = 32'd0;
        low_meas_d    = 32'd0;
        low_timer_d   = 32'd0;
      end
      if (need_comp_i) begin
        hold_start_d = now_seconds_i;
      end else if (!in_hold && (!check_enable_i || cnt_reset)) begin
        clear_done_d = 1'b1;
      end
      if (active) begin
        clear_done_d = 1'b0;
        high_timer_d = ht;
        full_armed_d = !at_full_i;
        if (rec_h) begin
          high_charge_d = hist_charge_i;
          high_dis_d    = hist_discharge_i;
          high_valid_d  = 1'b1;
        end
        if (e0) begin
          high_meas_d = stored;
          low_valid_d = 1'b0;
          low_timer_d = 32'd0;
        end
        if (discharging_i) begin
          low_timer_d = lt;
          if (uv_low) begin
            low_charge_d  = hist_charge_i;
            low_dis_d     = hist_discharge_i;
            low_valid_d   = 1'b1;
            empty_armed_d = 1'b0;
            if (e1) begin
              low_meas_d   = e0 ? 32'd0 : stored;
              high_valid_d = 1'b0;
              high_timer_d = 32'd0;
            end
          end else begin
            empty_armed_d = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_valid_q  <= 1'b0;
      high_charge_q <= 32'd0;
      high_dis_q    <= 32'd0;
      high_meas_q   <= 32'd0;
      high_timer_q  <= 32'd0;
      low_valid_q   <= 1'b0;
      low_charge_q  <= 32'd0;
      low_dis_q     <= 32'd0;
      low_meas_q    <= 32'd0;
      low_timer_q   <= 32'd0;
      hold_start_q  <= 32'd0;
      clear_done_q  <= 1'b0;
      full_armed_q  <= 1'b1;
      empty_armed_q <= 1'b1;
    end else begin
      high_valid_q  <= high_valid_d;
      high_charge_q <= high_charge_d;
      high_dis_q    <= high_dis_d;
      high_meas_q   <= high_meas_d;
      high_timer_q  <= high_timer_d;
      low_valid_q   <= low_valid_d;
      low_charge_q  <= low_charge_d;
      low_dis_q     <= low_dis_d;
      low_meas_q    <= low_meas_d;
      low_timer_q   <= low_timer_d;
      hold_start_q  <= hold_start_d;
      clear_done_q  <= clear_done_d;
      full_armed_q  <= full_armed_d;
      empty_armed_q <= empty_armed_d;
    end
  end

endmodule

/* rtl/core/bcl_queue.sv */
module bcl_queue #(
  parameter int unsigned Depth = bcl_pkg::QDEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  bcl_pkg::entry_t entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            head_valid_o,
  output bcl_pkg::entry_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  bcl_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o       = (cnt_q == CntW'(Depth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

/* rtl/core/bcl_back.sv */
module bcl_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  bcl_pkg::entry_t   head_i,
  output logic              pop_o,
  output logic              valid_o,
  input  logic              ready_i,
  output logic              source_o,
  output bcl_pkg::outcome_e outcome_o,
  output logic [31:0]       measured_cap_o,
  output logic [31:0]       new_total_o,
  output logic [9:0]        soc_o,
  output logic              drop_fault_o,
  output logic              last_o
);

  logic          valid_q, valid_d, sel_q, sel_d, fault_q, fault_d, load, is_last, corr;
  bcl_pkg::res_t cur;
  logic [32:0]   sum;

  logic              source_q, last_q;
  bcl_pkg::outcome_e outcome_q;
  logic [31:0]       meas_q, newt_q;
  logic [9:0]        soc_q;

  assign load    = head_valid_i && (!valid_q || ready_i);
  assign is_last = !(head_i.dual && !sel_q);
  assign cur     = sel_q ? head_i.r1 : head_i.r0;
  assign pop_o   = load && is_last;
  assign corr    = (cur.outcome == bcl_pkg::OUT_OPP) || (cur.outcome == bcl_pkg::OUT_TOTAL);
  assign sum     = 33'(cur.meas) + 33'(cur.ref_cap);

  always_comb begin
    sel_d   = load ? !is_last : sel_q;
    valid_d = load ? 1'b1 : (ready_i ? 1'b0 : valid_q);
    fault_d = fault_q;
    if (load) begin
      if (cur.outcome == bcl_pkg::OUT_REJECT) begin
        fault_d = 1'b1;
      end else if (corr) begin
        fault_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
      fault_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      sel_q   <= sel_d;
      fault_q <= fault_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      source_q  <= cur.source;
      outcome_q <= cur.outcome;
      meas_q    <= cur.meas;
      newt_q    <= corr ? sum[32:1] : 32'd0;
      soc_q     <= corr ? cur.soc : 10'd0;
      last_q    <= is_last;
    end
  end

  assign valid_o        = valid_q;
  assign source_o       = source_q;
  assign outcome_o      = outcome_q;
  assign measured_cap_o = meas_q;
  assign new_total_o    = newt_q;
  assign soc_o          = soc_q;
  assign drop_fault_o   = fault_q;
  assign last_o         = last_q;

endmodule

/* rtl/core/battery_capacity_learning.sv */
// Learns the pack's full capacity from pairs of full-charge and undervoltage checkpoints,
// one input request per one-second tick. A tick is taken every clock cycle while the
// result queue (QDepth entries) has room; the results of a tick pass through the result
// queue and the registered output stage before they reach the output, and a tick with two
// results sends two output transfers, tlast on the second. Registers at byte addresses 0x0
// enable, 0x4 min ticks, 0x8 max ticks, 0xC hold-off seconds; write them only while idle.
module battery_capacity_learning #(
  parameter int unsigned QDepth = bcl_pkg::QDEPTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // need_comp, now_seconds, hist_charge, hist_discharge, present_total,
  // discharging, at_full, under_voltage, real_soc, display_soc
  input  logic [151:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // outcome, measured_cap, new_total, soc_for_remaining, drop_fault, zero pad
  output logic [79:0]  m_axis_tdata,
  // source
  output logic [0:0]   m_axis_tuser,
  output logic         m_axis_tlast
);

  logic        check_enable_q;
  logic [31:0] min_ticks_q, max_ticks_q, holdoff_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      check_enable_q <= 1'b1;
      min_ticks_q    <= bcl_pkg::MIN_TICKS_RST;
      max_ticks_q    <= bcl_pkg::MAX_TICKS_RST;
      holdoff_q      <= bcl_pkg::HOLDOFF_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        bcl_pkg::REG_ENABLE:  check_enable_q <= pwdata[0];
        bcl_pkg::REG_MIN:     min_ticks_q    <= pwdata;
        bcl_pkg::REG_MAX:     max_ticks_q    <= pwdata;
        bcl_pkg::REG_HOLDOFF: holdoff_q      <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      bcl_pkg::REG_ENABLE:  prdata = {31'd0, check_enable_q};
      bcl_pkg::REG_MIN:     prdata = min_ticks_q;
      bcl_pkg::REG_MAX:     prdata = max_ticks_q;
      bcl_pkg::REG_HOLDOFF: prdata = holdoff_q;
      default:              prdata = 32'd0;
    endcase
  end

  logic              q_full, push, pop, head_valid;
  bcl_pkg::entry_t   entry, head;
  bcl_pkg::outcome_e outcome;
  logic [31:0]       measured_cap, new_total;
  logic [9:0]        soc_out;
  logic              drop_fault, source;

  bcl_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .valid_i           (s_axis_tvalid),
    .ready_o           (s_axis_tready),
    .need_comp_i       (s_axis_tdata[0]),
    .now_seconds_i     (s_axis_tdata[32:1]),
    .hist_charge_i     (s_axis_tdata[64:33]),
    .hist_discharge_i  (s_axis_tdata[96:65]),
    .present_total_i   (s_axis_tdata[128:97]),
    .discharging_i     (s_axis_tdata[129]),
    .at_full_i         (s_axis_tdata[130]),
    .under_voltage_i   (s_axis_tdata[131]),
    .real_soc_i        (s_axis_tdata[141:132]),
    .display_soc_i     (s_axis_tdata[151:142]),
    .check_enable_i    (check_enable_q),
    .min_cycle_ticks_i (min_ticks_q),
    .max_cycle_ticks_i (max_ticks_q),
    .holdoff_seconds_i (holdoff_q),
    .q_full_i          (q_full),
    .push_o            (push),
    .entry_o           (entry)
  );

  bcl_queue #(.Depth(QDepth)) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .entry_i      (entry),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  bcl_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (head_valid),
    .head_i         (head),
    .pop_o          (pop),
    .valid_o        (m_axis_tvalid),
    .ready_i        (m_axis_tready),
    .source_o       (source),
    .outcome_o      (outcome),
    .measured_cap_o (measured_cap),
    .new_total_o    (new_total),
    .soc_o          (soc_out),
    .drop_fault_o   (drop_fault),
    .last_o         (m_axis_tlast)
  );

  assign m_axis_tuser = source;
  assign m_axis_tdata = {3'd0, drop_fault, soc_out, new_total, measured_cap, outcome};

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full) else $error("result queue overflow");

  a_reject_sets_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && outcome == bcl_pkg::OUT_REJECT) |-> drop_fault)
    else $error("rejected measurement without drop fault");

  a_none_no_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && outcome == bcl_pkg::OUT_NONE) |-> (new_total == 32'd0 &&
                                                         measured_cap == 32'd0))
    else $error("unmeasurable result carries a figure");

endmodule
